### rtl/baidf_pkg.sv
// Package with the transaction types, codes and flag struct of the bounded array block.
package baidf_pkg;

  // Command codes carried in the input transaction.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  // Status codes carried in the result transaction.
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_BADPOS   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_FND_RD,
    S_FND_CMP,
    S_READ_RD,
    S_READ_CAP,
    S_FINISH
  } state_e;

  // Fixed field widths of the transactions.
  localparam int unsigned PosW   = 7;
  localparam int unsigned DataW  = 32;
  localparam int unsigned FidxW  = 6;
  localparam int unsigned CountW = 7;

  // Input transaction.
  typedef struct packed {
    cmd_e                     cmd;
    logic [PosW-1:0]          position;
    logic signed [DataW-1:0]  data_value;
  } in_t;

  // Result transaction.
  typedef struct packed {
    status_e                  status;
    logic [FidxW-1:0]         found_index;
    logic [CountW-1:0]        match_count;
    logic signed [DataW-1:0]  read_value;
    logic [CountW-1:0]        entry_count;
  } out_t;

  // Compare results from the shared step unit.
  typedef struct packed {
    logic idx_eq;
    logic nxt_eq;
    logic val_eq;
  } unit_flags_t;

endpackage

### rtl/baidf_unit.sv
// Shared step unit: index increment or decrement plus index and value compares.
module baidf_unit #(
  parameter int unsigned CW = 7
) (
  input  logic [CW-1:0]                  idx_i,
  input  logic                           dec_i,
  input  logic [CW-1:0]                  ref_i,
  input  logic [baidf_pkg::DataW-1:0]    a_i,
  input  logic [baidf_pkg::DataW-1:0]    b_i,
  output logic [CW-1:0]                  nxt_o,
  output baidf_pkg::unit_flags_t         flags_o
);

  // Step the index one place up or down.
  assign nxt_o = dec_i ? (idx_i - CW'(1)) : (idx_i + CW'(1));

  // Loop end tests and the value match for searches.
  assign flags_o.idx_eq = (idx_i == ref_i);
  assign flags_o.nxt_eq = (nxt_o == ref_i);
  assign flags_o.val_eq = (a_i == b_i);

endmodule

### rtl/bounded_array_insert_delete_find.sv
// Top level of the bounded ordered array with insert, delete, find and read.
//
// The block holds up to DEPTH signed 32-bit entries in a single-port-style
// memory (one write and one registered read per cycle) and serves one command
// per transaction. All element moves and compares go through one shared step
// unit, with a read state and a write or compare state for each element. A
// rejected command (full, empty, bad position) goes from the range checks
// straight to the result. The input is not ready while a command is in
// progress; a finished result waits in the output register, so the next
// command can be accepted before the previous result is taken. Memory
// contents need no clearing after reset, since only entries below the count
// are ever read.
module bounded_array_insert_delete_find #(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  baidf_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output baidf_pkg::out_t  out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > baidf_pkg::PosW) ? CW : baidf_pkg::PosW;

  // Sequencer and transaction registers.
  baidf_pkg::state_e  state_q, state_d;
  baidf_pkg::cmd_e    cmd_q, cmd_d;
  logic [baidf_pkg::PosW-1:0]  pos_q, pos_d;
  logic [baidf_pkg::DataW-1:0] val_q, val_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      nmatch_q, nmatch_d;
  logic [CW-1:0]      fidx_q, fidx_d;
  logic [baidf_pkg::DataW-1:0] rval_q, rval_d;
  baidf_pkg::status_e stat_q, stat_d;
  logic               out_valid_q, out_valid_d;
  baidf_pkg::out_t    out_q, out_d;

  // Memory ports.
  logic [baidf_pkg::DataW-1:0] mem_q [DEPTH];
  logic [baidf_pkg::DataW-1:0] rd_data_q;
  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [baidf_pkg::DataW-1:0] wr_data;

  // Shared step unit.
  logic                   unit_dec;
  logic [CW-1:0]          unit_ref;
  logic [CW-1:0]          unit_nxt;
  baidf_pkg::unit_flags_t unit_flags;

  // Widened views for compares and for masking into the result fields.
  logic [XW-1:0] pos_x, cnt_x, cnt_new_x, nmatch_x, fidx_x;
  logic [CW-1:0] cnt_new;
  logic          out_free;

  assign pos_x    = XW'(pos_q);
  assign cnt_x    = XW'(count_q);
  assign nmatch_x = XW'(nmatch_q);
  assign fidx_x   = XW'(fidx_q);
  assign out_free = !out_valid_q || out_ready_i;

  baidf_unit #(
    .CW (CW)
  ) u_unit (
    .idx_i   (idx_q),
    .dec_i   (unit_dec),
    .ref_i   (unit_ref),
    .a_i     (rd_data_q),
    .b_i     (val_q),
    .nxt_o   (unit_nxt),
    .flags_o (unit_flags)
  );

  // Entry count after the current command completes.
  always_comb begin
    cnt_new = count_q;
    if (stat_q == baidf_pkg::STAT_OK) begin
      if (cmd_q == baidf_pkg::CMD_INSERT) begin
        cnt_new = count_q + CW'(1);
      end else if (cmd_q == baidf_pkg::CMD_DELETE) begin
        cnt_new = count_q - CW'(1);
      end
    end
  end
  assign cnt_new_x = XW'(cnt_new);

  // Sequencer: next state, loop control and memory requests.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    val_d       = val_q;
    count_d     = count_q;
    idx_d       = idx_q;
    nmatch_d    = nmatch_q;
    fidx_d      = fidx_q;
    rval_d      = rval_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_q[AW-1:0];
    wr_data     = rd_data_q;
    unit_dec    = 1'b0;
    unit_ref    = count_q;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      baidf_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = in_data_i.cmd;
          pos_d   = in_data_i.position;
          val_d   = in_data_i.data_value;
          state_d = baidf_pkg::S_DECIDE;
        end
      end

      // Range checks and loop setup.
      baidf_pkg::S_DECIDE: begin
        stat_d   = baidf_pkg::STAT_OK;
        nmatch_d = '0;
        fidx_d   = '0;
        rval_d   = '0;
        case (cmd_q)
          baidf_pkg::CMD_INSERT: begin
            if (count_q == CW'(DEPTH)) begin
              stat_d  = baidf_pkg::STAT_FULL;
              state_d = baidf_pkg::S_FINISH;
            end else if (pos_x > cnt_x) begin
              stat_d  = baidf_pkg::STAT_BADPOS;
              state_d = baidf_pkg::S_FINISH;
            end else begin
              idx_d   = count_q;
              state_d = baidf_pkg::S_INS_RD;
            end
          end
          baidf_pkg::CMD_DELETE: begin
            if (count_q == '0) begin
              stat_d  = baidf_pkg::STAT_EMPTY;
              state_d = baidf_pkg::S_FINISH;
            end else if (pos_x >= cnt_x) begin
              stat_d  = baidf_pkg::STAT_BADPOS;
              state_d = baidf_pkg::S_FINISH;
            end else begin
              idx_d   = pos_x[CW-1:0];
              state_d = baidf_pkg::S_DEL_RD;
            end
          end
          baidf_pkg::CMD_FIND: begin
            idx_d   = '0;
            state_d = baidf_pkg::S_FND_RD;
          end
          default: begin
            if (count_q == '0) begin
              stat_d  = baidf_pkg::STAT_EMPTY;
              state_d = baidf_pkg::S_FINISH;
            end else if (pos_x >= cnt_x) begin
              stat_d  = baidf_pkg::STAT_BADPOS;
              state_d = baidf_pkg::S_FINISH;
            end else begin
              state_d = baidf_pkg::S_READ_RD;
            end
          end
        endcase
      end

      // Insert: move entries up one place, from the end down to the position.
      baidf_pkg::S_INS_RD: begin
        unit_dec = 1'b1;
        unit_ref = pos_x[CW-1:0];
        if (unit_flags.idx_eq) begin
          state_d = baidf_pkg::S_INS_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = unit_nxt[AW-1:0];
          state_d = baidf_pkg::S_INS_WR;
        end
      end

      baidf_pkg::S_INS_WR: begin
        unit_dec = 1'b1;
        wr_en    = 1'b1;
        idx_d    = unit_nxt;
        state_d  = baidf_pkg::S_INS_RD;
      end

      baidf_pkg::S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_x[AW-1:0];
        wr_data = val_q;
        state_d = baidf_pkg::S_FINISH;
      end

      // Delete: move later entries down one place to close the gap.
      baidf_pkg::S_DEL_RD: begin
        if (unit_flags.nxt_eq) begin
          state_d = baidf_pkg::S_FINISH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = unit_nxt[AW-1:0];
          state_d = baidf_pkg::S_DEL_WR;
        end
      end

      baidf_pkg::S_DEL_WR: begin
        wr_en   = 1'b1;
        idx_d   = unit_nxt;
        state_d = baidf_pkg::S_DEL_RD;
      end

      // Find: walk all stored entries, keeping the last match.
      baidf_pkg::S_FND_RD: begin
        if (unit_flags.idx_eq) begin
          if (nmatch_q == '0) begin
            stat_d = baidf_pkg::STAT_NOTFOUND;
          end
          state_d = baidf_pkg::S_FINISH;
        end else begin
          rd_en   = 1'b1;
          state_d = baidf_pkg::S_FND_CMP;
        end
      end

      baidf_pkg::S_FND_CMP: begin
        if (unit_flags.val_eq) begin
          nmatch_d = nmatch_q + CW'(1);
          fidx_d   = idx_q;
        end
        idx_d   = unit_nxt;
        state_d = baidf_pkg::S_FND_RD;
      end

      // Read one entry.
      baidf_pkg::S_READ_RD: begin
        rd_en   = 1'b1;
        rd_addr = pos_x[AW-1:0];
        state_d = baidf_pkg::S_READ_CAP;
      end

      baidf_pkg::S_READ_CAP: begin
        rval_d  = rd_data_q;
        state_d = baidf_pkg::S_FINISH;
      end

      // Hand the result to the output register once it is free.
      baidf_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = stat_q;
          out_d.found_index = fidx_x[baidf_pkg::FidxW-1:0];
          out_d.match_count = nmatch_x[baidf_pkg::CountW-1:0];
          out_d.read_value  = rval_q;
          out_d.entry_count = cnt_new_x[baidf_pkg::CountW-1:0];
          count_d           = cnt_new;
          state_d           = baidf_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = baidf_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= baidf_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    nmatch_q <= nmatch_d;
    fidx_q   <= fidx_d;
    rval_q   <= rval_d;
    stat_q   <= stat_d;
    out_q    <= out_d;
  end

  // Entry memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/baidf_checker.sv
// Port-level checker for the bounded array block and its bind statement.
module baidf_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input baidf_pkg::out_t  out_data_o
);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Accepting a command takes the block out of idle, so input ready drops.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted transaction");

  // The reported entry count never exceeds the capacity (checked for DEPTH up to 127).
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 127) || (out_data_o.entry_count <= DEPTH))
    else $error("entry count above capacity");

  // A failed search reports no index and no matches.
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == baidf_pkg::STAT_NOTFOUND)
      |-> (out_data_o.found_index == '0) && (out_data_o.match_count == '0))
    else $error("not-found result carries match data");

  // Read data appears only on a successful transaction.
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.read_value != '0)
      |-> out_data_o.status == baidf_pkg::STAT_OK)
    else $error("read value on a failed transaction");

endmodule

bind bounded_array_insert_delete_find baidf_checker #(
  .DEPTH (DEPTH)
) u_baidf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
